FILE: sv/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types for the three-wire serial writer: request and result words
// and the push bundle that goes from the core to the result queue.
// ----------------------------------------------------------------------------
package tsw_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
  } req_word_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic select_line;
    logic busy_res;
    logic last;
  } rsp_word_t;

  typedef struct packed {
    logic      push_one;
    logic      push_two;
    rsp_word_t first;
    rsp_word_t second;
  } push_t;

endpackage

FILE: sv/tsw_req_if.sv
// ----------------------------------------------------------------------------
// tsw_req_if
// Request channel: valid, ready and one request word.
// ----------------------------------------------------------------------------
interface tsw_req_if;
  import tsw_pkg::*;

  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [31:0] write_data;
  logic [2:0]  byte_count;

  modport source (output valid, output opcode, output write_data, output byte_count,
                  input ready);
  modport sink (input valid, input opcode, input write_data, input byte_count,
                output ready);
endinterface

FILE: sv/tsw_rsp_if.sv
// ----------------------------------------------------------------------------
// tsw_rsp_if
// Result channel: valid, ready and the pin levels of one result word.
// ----------------------------------------------------------------------------
interface tsw_rsp_if;
  logic valid;
  logic ready;
  logic clock_line;
  logic data_line;
  logic select_line;
  logic busy_res;
  logic last;

  modport source (output valid, output clock_line, output data_line, output select_line,
                  output busy_res, output last, input ready);
  modport sink (input valid, input clock_line, input data_line, input select_line,
                input busy_res, input last, output ready);
endinterface

FILE: sv/tsw_cfg_if.sv
// ----------------------------------------------------------------------------
// tsw_cfg_if
// Configuration write channel carrying the clock idle level.
// ----------------------------------------------------------------------------
interface tsw_cfg_if;
  logic valid;
  logic ready;
  logic clock_idle_high;

  modport source (output valid, output clock_idle_high, input ready);
  modport sink (input valid, input clock_idle_high, output ready);
endinterface

FILE: sv/tsw_core.sv
// ----------------------------------------------------------------------------
// tsw_core
// Transfer state and per-word update: start loading, tick sequencing,
// shift-out and the result words each request word produces.
// ----------------------------------------------------------------------------
module tsw_core #(
  parameter int MAX_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tsw_pkg::req_word_t req_word,
  input  logic               cfg_write,
  input  logic               cfg_idle_high,
  output tsw_pkg::push_t     push
);
  import tsw_pkg::*;

  localparam int BW    = $clog2(MAX_BYTES + 1);
  localparam int TW    = $clog2(MAX_BYTES * 16 + 1);
  localparam int PWRAW = $clog2(MAX_BYTES * 8);
  localparam int PW    = (PWRAW > 6) ? PWRAW : 6;

  logic [31:0]   shift_buffer, shift_buffer_next;
  logic [TW-1:0] tick_index, tick_index_next;
  logic [BW-1:0] bytes_in_use, bytes_in_use_next;
  logic          clock_level, clock_level_next;
  logic          data_level, data_level_next;
  logic          select_level, select_level_next;
  logic          in_transfer, in_transfer_next;
  logic          clock_idle_high;

  logic [PW-1:0] top_pos;
  logic          top_bit;
  logic [BW-1:0] count_sat;
  logic [TW-1:0] tick_limit;
  logic          final_tick;

  assign top_pos    = PW'(bytes_in_use) * PW'(8) - PW'(1);
  assign top_bit    = (top_pos < PW'(32)) ? shift_buffer[top_pos[4:0]] : 1'b0;
  assign tick_limit = TW'(bytes_in_use) << 4;
  assign final_tick = (tick_index != '0) && !(tick_index < tick_limit);

  always_comb begin
    if (req_word.byte_count == 3'd0) begin
      count_sat = BW'(1);
    end else if ({1'b0, req_word.byte_count} > 4'(MAX_BYTES)) begin
      count_sat = BW'(MAX_BYTES);
    end else begin
      count_sat = BW'(req_word.byte_count);
    end
  end

  always_comb begin
    shift_buffer_next = shift_buffer;
    tick_index_next   = tick_index;
    bytes_in_use_next = bytes_in_use;
    clock_level_next  = clock_level;
    data_level_next   = data_level;
    select_level_next = select_level;
    in_transfer_next  = in_transfer;
    if (req_word.opcode == OP_START) begin
      if (!in_transfer) begin
        bytes_in_use_next = count_sat;
        shift_buffer_next = req_word.write_data;
        clock_level_next  = clock_idle_high;
        select_level_next = 1'b1;
        tick_index_next   = '0;
        in_transfer_next  = 1'b1;
      end
    end else if (in_transfer) begin
      if (tick_index == '0) begin
        clock_level_next  = 1'b0;
        select_level_next = 1'b0;
        data_level_next   = top_bit;
        shift_buffer_next = shift_buffer << 1;
        tick_index_next   = tick_index + TW'(1);
      end else if (!final_tick) begin
        clock_level_next = ~clock_level;
        if (clock_level) begin
          data_level_next   = top_bit;
          shift_buffer_next = shift_buffer << 1;
        end
        tick_index_next = tick_index + TW'(1);
      end else begin
        clock_level_next  = ~clock_level;
        select_level_next = 1'b1;
        in_transfer_next  = 1'b0;
      end
    end
  end

  always_comb begin
    push.push_one           = accept;
    push.push_two           = accept && (req_word.opcode == OP_TICK) && in_transfer &&
                              final_tick;
    push.first.clock_line   = clock_level_next;
    push.first.data_line    = data_level_next;
    push.first.select_line  = select_level_next;
    push.first.busy_res     = in_transfer_next;
    push.first.last         = !push.push_two;
    push.second.clock_line  = 1'b1;
    push.second.data_line   = data_level_next;
    push.second.select_line = select_level_next;
    push.second.busy_res    = in_transfer_next;
    push.second.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_buffer    <= '0;
      tick_index      <= '0;
      bytes_in_use    <= BW'(1);
      clock_level     <= 1'b1;
      data_level      <= 1'b1;
      select_level    <= 1'b1;
      in_transfer     <= 1'b0;
      clock_idle_high <= 1'b1;
    end else begin
      if (accept) begin
        shift_buffer <= shift_buffer_next;
        tick_index   <= tick_index_next;
        bytes_in_use <= bytes_in_use_next;
        clock_level  <= push.push_two ? 1'b1 : clock_level_next;
        data_level   <= data_level_next;
        select_level <= select_level_next;
        in_transfer  <= in_transfer_next;
      end
      if (cfg_write) begin
        clock_idle_high <= cfg_idle_high;
      end
    end
  end

endmodule

FILE: sv/tsw_rsp_queue.sv
// ----------------------------------------------------------------------------
// tsw_rsp_queue
// Four-entry result queue taking one or two words per cycle and
// presenting one word per cycle to the result channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module tsw_rsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  tsw_pkg::push_t     push,
  output logic               space,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output tsw_pkg::rsp_word_t rsp_word
);
  import tsw_pkg::*;

  rsp_word_t  entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign rsp_valid = (count != 3'd0);
  assign rsp_word  = entry[rd_ptr];
  assign pop       = rsp_valid && rsp_ready;
  assign space     = (count <= 3'd2);

  always_comb begin
    count_next = count;
    if (push.push_two) begin
      count_next = count_next + 3'd2;
    end else if (push.push_one) begin
      count_next = count_next + 3'd1;
    end
    if (pop) begin
      count_next = count_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_one) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.push_two) begin
      entry[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push_two) begin
        wr_ptr <= wr_ptr + 2'd2;
      end else if (push.push_one) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule

FILE: sv/three_wire_serial_writer.sv
// ----------------------------------------------------------------------------
// three_wire_serial_writer
// Write-only three-wire serial master stepped by tick and start words.
//
// Channels: req takes start words (data and byte count) and tick words;
// rsp returns the clock, data and select pin levels plus busy after each
// word, with last marking the final result of that word; cfg writes the
// clock idle level used when a write starts (always ready).
// Results are written into the result queue when their request word is taken.
// Throughput: one request word per cycle. The tick that ends a transfer
// yields two results; the four-entry result queue absorbs the extra word
// and req.ready drops only while fewer than two queue entries are free.
// Reset: state returns to idle with all lines high and the queue empty.
// Stall: while rsp.ready is low results hold in the queue, and req is
// taken until fewer than two queue entries are free.
// ----------------------------------------------------------------------------
module three_wire_serial_writer #(
  parameter int MAX_BYTES = 4
) (
  input logic        clk,
  input logic        rst,
  tsw_req_if.sink    req,
  tsw_rsp_if.source  rsp,
  tsw_cfg_if.sink    cfg
);
  import tsw_pkg::*;

  req_word_t req_word;
  rsp_word_t rsp_word;
  push_t     push;
  logic      space;
  logic      accept;

  assign req.ready           = space;
  assign cfg.ready           = 1'b1;
  assign accept              = req.valid && space;
  assign req_word.opcode     = req.opcode;
  assign req_word.write_data = req.write_data;
  assign req_word.byte_count = req.byte_count;

  tsw_core #(.MAX_BYTES(MAX_BYTES)) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req_word      (req_word),
    .cfg_write     (cfg.valid),
    .cfg_idle_high (cfg.clock_idle_high),
    .push          (push)
  );

  tsw_rsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp_word)
  );

  assign rsp.clock_line  = rsp_word.clock_line;
  assign rsp.data_line   = rsp_word.data_line;
  assign rsp.select_line = rsp_word.select_line;
  assign rsp.busy_res    = rsp_word.busy_res;
  assign rsp.last        = rsp_word.last;

endmodule

FILE: sv/tsw_checker.sv
// ----------------------------------------------------------------------------
// tsw_checker
// Port-level checks for the three-wire serial writer, bound to the top.
// ----------------------------------------------------------------------------
module tsw_checker (
  input logic clk,
  input logic rst,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_clock_line,
  input logic rsp_data_line,
  input logic rsp_select_line,
  input logic rsp_busy_res,
  input logic rsp_last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clock_line) &&
      $stable(rsp_data_line) && $stable(rsp_select_line) &&
      $stable(rsp_busy_res) && $stable(rsp_last))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !rsp_busy_res && rsp_select_line)
    else $error("transfer end result not idle");

  a_end_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last && rsp_clock_line &&
      !rsp_busy_res)
    else $error("clock restore result missing after transfer end");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind three_wire_serial_writer tsw_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_clock_line  (rsp.clock_line),
  .rsp_data_line   (rsp.data_line),
  .rsp_select_line (rsp.select_line),
  .rsp_busy_res    (rsp.busy_res),
  .rsp_last        (rsp.last)
);
